/* hdl/kms_pkg.sv */
// ----------------------------------------------------------------------------
// kms_pkg: shared types and constants for the k-mer minimizer stream
// Beat payloads, configuration codes, the front-to-back record, the back-end
// state type and the base decode and group reverse functions.
// ----------------------------------------------------------------------------
package kms_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 8'd1;

  localparam logic [5:0] KMER_LENGTH_RST   = 6'd15;
  localparam logic [4:0] WINDOW_LENGTH_RST = 5'd10;
  localparam int unsigned WINDOW_MIN = 5;
  localparam logic [5:0] KMER_MIN  = 6'd1;
  localparam logic [5:0] KMER_MAX  = 6'd32;
  localparam logic [5:0] FILL_MAX  = 6'd63;

  // front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // character codes
  localparam logic [7:0] CHAR_A_UP = 8'h41;
  localparam logic [7:0] CHAR_C_UP = 8'h43;
  localparam logic [7:0] CHAR_G_UP = 8'h47;
  localparam logic [7:0] CHAR_T_UP = 8'h54;
  localparam logic [7:0] CHAR_A_LO = 8'h61;
  localparam logic [7:0] CHAR_C_LO = 8'h63;
  localparam logic [7:0] CHAR_G_LO = 8'h67;
  localparam logic [7:0] CHAR_T_LO = 8'h74;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef struct packed {
    logic       start_of_sequence;
    logic [7:0] base_char;
  } kms_in_t;

  typedef struct packed {
    logic [31:0] base_position;
    logic        kmer_valid;
    logic [63:0] canonical_kmer;
    logic        new_minimizer;
    logic [31:0] minimizer_position;
    logic [63:0] minimizer_value;
  } kms_out_t;

  typedef struct packed {
    logic [5:0] kmer_length;
    logic [4:0] window_length;
  } kms_cfg_t;

  // one classified character, front to back
  typedef struct packed {
    logic [31:0] pos;
    logic        sos;     // clear window and last minimum first
    logic        bad;     // not a base: clear track, zero result
    logic        kvalid;  // full k-mer ends here
    logic [63:0] fwd;     // forward k-mer, masked to k bases
    logic [5:0]  k;       // effective k-mer length
  } kms_rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_REV,
    BK_PUSH,
    BK_SCAN,
    BK_DECIDE,
    BK_EMIT
  } kms_state_t;

  // {ok, code}
  function automatic logic [2:0] decode_base(input logic [7:0] c);
    logic [2:0] r;
    unique case (c) inside
      CHAR_A_UP, CHAR_A_LO: r = {1'b1, BASE_A};
      CHAR_C_UP, CHAR_C_LO: r = {1'b1, BASE_C};
      CHAR_G_UP, CHAR_G_LO: r = {1'b1, BASE_G};
      CHAR_T_UP, CHAR_T_LO: r = {1'b1, BASE_T};
      default:              r = {1'b0, BASE_A};
    endcase
    return r;
  endfunction

  // clamp k to 1..32
  function automatic logic [5:0] eff_k(input logic [5:0] k);
    logic [5:0] r;
    if (k < KMER_MIN) begin
      r = KMER_MIN;
    end else if (k > KMER_MAX) begin
      r = KMER_MAX;
    end else begin
      r = k;
    end
    return r;
  endfunction

  // reverse the order of the 32 two-bit groups
  function automatic logic [63:0] rev_groups(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 32; i++) begin
      r[2*i +: 2] = x[62-2*i +: 2];
    end
    return r;
  endfunction

endpackage

/* hdl/kms_front.sv */
// ----------------------------------------------------------------------------
// kms_front: character intake and classification
// Tracks position, rolling forward k-mer and fill count, and turns each
// accepted character into one record for the back end.
// ----------------------------------------------------------------------------
module kms_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,      // input beat accepted this cycle
  input  kms_pkg::kms_in_t  in_item,
  input  kms_pkg::kms_cfg_t cfg,
  output kms_pkg::kms_rec_t rec
);

  logic [31:0] pos_r, pos_nxt;
  logic [63:0] roll_r, roll_nxt;
  logic [5:0]  fill_r, fill_nxt;

  logic [31:0] pos_cur;
  logic [63:0] roll_base;
  logic [5:0]  fill_base;
  logic [2:0]  dec;
  logic [5:0]  k;
  logic [63:0] kmask;

  // decode and mask
  assign dec   = kms_pkg::decode_base(in_item.base_char);
  assign k     = kms_pkg::eff_k(cfg.kmer_length);
  assign kmask = ~({64{1'b1}} << {k, 1'b0});

  // start marker restarts the track before this character
  always_comb begin
    pos_cur   = in_item.start_of_sequence ? 32'd0 : pos_r;
    roll_base = in_item.start_of_sequence ? 64'd0 : roll_r;
    fill_base = in_item.start_of_sequence ? 6'd0  : fill_r;
  end

  // rolling k-mer update
  always_comb begin
    pos_nxt  = pos_r;
    roll_nxt = roll_r;
    fill_nxt = fill_r;
    if (take) begin
      pos_nxt = pos_cur + 32'd1;
      if (!dec[2]) begin
        roll_nxt = 64'd0;
        fill_nxt = 6'd0;
      end else begin
        roll_nxt = {roll_base[61:0], dec[1:0]} & kmask;
        fill_nxt = (fill_base < kms_pkg::FILL_MAX) ? fill_base + 6'd1 : fill_base;
      end
    end
  end

  // record for the queue
  always_comb begin
    rec.pos    = pos_cur;
    rec.sos    = in_item.start_of_sequence;
    rec.bad    = !dec[2];
    rec.kvalid = dec[2] && (fill_nxt >= k);
    rec.fwd    = roll_nxt;
    rec.k      = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 32'd0;
      roll_r <= 64'd0;
      fill_r <= 6'd0;
    end else begin
      pos_r  <= pos_nxt;
      roll_r <= roll_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

/* hdl/kms_queue.sv */
// ----------------------------------------------------------------------------
// kms_queue: short record queue between front and back
// Register queue; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module kms_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kms_pkg::kms_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output kms_pkg::kms_rec_t pop_rec
);

  localparam int unsigned DEPTH = kms_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  kms_pkg::kms_rec_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_rec   = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_rec;
    end
  end

endmodule

/* hdl/kms_back.sv */
// ----------------------------------------------------------------------------
// kms_back: canonical form, window and minimizer selection
// Takes one record at a time: reverse complement, window shift, a serial
// scan for the minimum from the oldest entry, and the output register.
// ----------------------------------------------------------------------------
module kms_back #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kms_pkg::kms_cfg_t cfg,
  input  logic              q_valid,
  input  kms_pkg::kms_rec_t q_rec,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output kms_pkg::kms_out_t out_data
);

  localparam int unsigned IW = $clog2(MAX_WINDOW);
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);

  kms_pkg::kms_state_t state_r, state_nxt;

  kms_pkg::kms_rec_t rec_r, rec_nxt;
  logic [63:0] rc_r, rc_nxt;
  logic [63:0] canon_r, canon_nxt;
  logic [63:0] win_val_r [MAX_WINDOW];
  logic [63:0] win_val_nxt [MAX_WINDOW];
  logic [31:0] win_pos_r [MAX_WINDOW];
  logic [31:0] win_pos_nxt [MAX_WINDOW];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0] last_min_r, last_min_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [63:0] mv_r, mv_nxt;
  logic [31:0] mp_r, mp_nxt;
  logic        newmin_r, newmin_nxt;
  logic        out_valid_r, out_valid_nxt;
  kms_pkg::kms_out_t out_data_r, out_data_nxt;

  logic [CW-1:0] w_eff;
  logic [IW-1:0] w_last;
  logic [CW-1:0] cnt_inc;
  logic [63:0]   canon_cur;
  logic [63:0]   scan_val;
  logic          scan_take;
  logic          out_free;

  // effective window length
  always_comb begin
    if (cfg.window_length < 5'(kms_pkg::WINDOW_MIN)) begin
      w_eff = CW'(kms_pkg::WINDOW_MIN);
    end else if (32'(cfg.window_length) > 32'(MAX_WINDOW)) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = CW'(cfg.window_length);
    end
  end

  assign w_last    = IW'(w_eff - 1'b1);
  assign cnt_inc   = (cnt_r < CW'(MAX_WINDOW)) ? cnt_r + 1'b1 : cnt_r;
  assign canon_cur = (rc_r < rec_r.fwd) ? rc_r : rec_r.fwd;
  assign scan_val  = win_val_r[idx_r];
  assign scan_take = (idx_r == w_last) || (scan_val < mv_r);
  assign out_free  = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kms_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = q_rec.kvalid ? kms_pkg::BK_REV : kms_pkg::BK_EMIT;
        end
      end
      kms_pkg::BK_REV: begin
        state_nxt = kms_pkg::BK_PUSH;
      end
      kms_pkg::BK_PUSH: begin
        state_nxt = (cnt_inc >= w_eff) ? kms_pkg::BK_SCAN : kms_pkg::BK_EMIT;
      end
      kms_pkg::BK_SCAN: begin
        if (idx_r == '0) begin
          state_nxt = kms_pkg::BK_DECIDE;
        end
      end
      kms_pkg::BK_DECIDE: begin
        state_nxt = kms_pkg::BK_EMIT;
      end
      kms_pkg::BK_EMIT: begin
        if (out_free) begin
          state_nxt = kms_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = kms_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop        = 1'b0;
    rec_nxt      = rec_r;
    rc_nxt       = rc_r;
    canon_nxt    = canon_r;
    win_val_nxt  = win_val_r;
    win_pos_nxt  = win_pos_r;
    cnt_nxt      = cnt_r;
    last_min_nxt = last_min_r;
    idx_nxt      = idx_r;
    mv_nxt       = mv_r;
    mp_nxt       = mp_r;
    newmin_nxt   = newmin_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      kms_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rec_nxt    = q_rec;
          newmin_nxt = 1'b0;
          if (q_rec.sos || q_rec.bad) begin
            cnt_nxt      = '0;
            last_min_nxt = '1;
          end
        end
      end
      kms_pkg::BK_REV: begin
        rc_nxt = kms_pkg::rev_groups(~rec_r.fwd) >> (7'd64 - {rec_r.k, 1'b0});
      end
      kms_pkg::BK_PUSH: begin
        // newest entry at index zero
        for (int i = 1; i < int'(MAX_WINDOW); i++) begin
          win_val_nxt[i] = win_val_r[i-1];
          win_pos_nxt[i] = win_pos_r[i-1];
        end
        win_val_nxt[0] = canon_cur;
        win_pos_nxt[0] = rec_r.pos;
        canon_nxt      = canon_cur;
        cnt_nxt        = cnt_inc;
        idx_nxt        = w_last;
      end
      kms_pkg::BK_SCAN: begin
        // oldest first, strict less keeps the earliest on ties
        if (scan_take) begin
          mv_nxt = scan_val;
          mp_nxt = win_pos_r[idx_r];
        end
        if (idx_r != '0) begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      kms_pkg::BK_DECIDE: begin
        if (mv_r != last_min_r) begin
          last_min_nxt = mv_r;
          newmin_nxt   = 1'b1;
        end
      end
      kms_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.base_position      = rec_r.pos;
          out_data_nxt.kmer_valid         = rec_r.kvalid;
          out_data_nxt.canonical_kmer     = rec_r.kvalid ? canon_r : 64'd0;
          out_data_nxt.new_minimizer      = newmin_r;
          out_data_nxt.minimizer_position = newmin_r ? mp_r : 32'd0;
          out_data_nxt.minimizer_value    = newmin_r ? mv_r : 64'd0;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kms_pkg::BK_IDLE;
      cnt_r       <= '0;
      last_min_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_min_r  <= last_min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rec_r      <= rec_nxt;
    rc_r       <= rc_nxt;
    canon_r    <= canon_nxt;
    win_val_r  <= win_val_nxt;
    win_pos_r  <= win_pos_nxt;
    idx_r      <= idx_nxt;
    mv_r       <= mv_nxt;
    mp_r       <= mp_nxt;
    newmin_r   <= newmin_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* hdl/kmer_minimizer_stream.sv */
// A beat that ends no full k-mer goes from IDLE to EMIT in the back end; one
// that ends a k-mer passes IDLE, REV and PUSH, then EMIT while the window
// fills, or SCAN and DECIDE before EMIT once the window (w k-mers) is full,
// the serial minimum scan taking one entry per cycle. The next record is
// popped after EMIT. A 2-entry queue lets intake run ahead.
// Synchronous active-low reset clears all control state, registers 15 and 10.
// ----------------------------------------------------------------------------
// kmer_minimizer_stream: streaming canonical k-mer minimizer selection
// Configuration registers, front intake, record queue and back end.
// ----------------------------------------------------------------------------
module kmer_minimizer_stream #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  kms_pkg::kms_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output kms_pkg::kms_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  kms_pkg::kms_cfg_t cfg_r, cfg_nxt;
  kms_pkg::kms_rec_t front_rec, q_rec;
  logic q_full, q_valid, q_pop, take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        kms_pkg::CFG_KMER_LENGTH:   cfg_nxt.kmer_length   = cfg_data[5:0];
        kms_pkg::CFG_WINDOW_LENGTH: cfg_nxt.window_length = cfg_data[4:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kmer_length   <= kms_pkg::KMER_LENGTH_RST;
      cfg_r.window_length <= kms_pkg::WINDOW_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kms_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_item (in_data),
    .cfg     (cfg_r),
    .rec     (front_rec)
  );

  kms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_rec  (front_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_rec   (q_rec)
  );

  kms_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // no k-mer, no minimizer
  a_no_kmer_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.kmer_valid |->
      !out_data.new_minimizer && out_data.canonical_kmer == 64'd0)
    else $error("minimizer or k-mer value on a beat without a k-mer");

  // newest k-mer is inside the window, so the minimum cannot exceed it
  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_minimizer |->
      out_data.minimizer_value <= out_data.canonical_kmer)
    else $error("minimizer larger than the newest k-mer");

  // minimizer fields zero unless a new minimizer is reported
  a_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.new_minimizer |->
      out_data.minimizer_value == 64'd0 && out_data.minimizer_position == 32'd0)
    else $error("stale minimizer fields");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kmer_minimizer_stream
// Drives characters and register writes over valid/ready channels with random
// idle bursts on both sides. A behavioral model of the rolling k-mer, its
// canonical form and the minimizer window predicts each result beat not typed
// in the directed table; output beats are checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WIN_DEPTH   = 16;
  localparam int unsigned RAND_ITEMS  = 2000;
  localparam int unsigned TAIL_ITEMS  = 300;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 600000;
  // index with no register behind it, writes must be dropped
  localparam logic [kms_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 8'd2;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // directed stimulus row: a character beat or a register write
  typedef struct packed {
    row_kind_t   kind;
    logic        sos;
    logic [7:0]  idx;
    logic [7:0]  val;       // character, or register data
    logic        typed;     // expected result given below, minimizer fields zero
    logic [31:0] t_pos;
    logic        t_kvalid;
    logic [63:0] t_kmer;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 31;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // reset settings, k=15 w=10: first bases, lowest and highest bytes
    '{ROW_BEAT, 1'b1, 8'h00, kms_pkg::CHAR_A_UP, 1'b1, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_C_LO, 1'b1, 32'd1, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, 8'h00,              1'b1, 32'd2, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, 8'hFF,              1'b1, 32'd3, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, 8'h4E,              1'b1, 32'd4, 1'b0, 64'd0},
    // shortest k-mer, smallest window
    '{ROW_CFG,  1'b0, kms_pkg::CFG_KMER_LENGTH,   8'd1, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_CFG,  1'b0, kms_pkg::CFG_WINDOW_LENGTH, 8'd5, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b1, 8'h00, kms_pkg::CHAR_T_UP, 1'b1, 32'd0, 1'b1, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_G_LO, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_C_UP, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_A_LO, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_T_LO, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_G_UP, 1'b0, 32'd0, 1'b0, 64'd0},
    // neighbors of the letters, not bases
    '{ROW_BEAT, 1'b0, 8'h00, 8'h40,              1'b1, 32'd6, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, 8'h75,              1'b1, 32'd7, 1'b0, 64'd0},
    // zero k-mer length and short window clamp; equal k-mers tie
    '{ROW_CFG,  1'b0, kms_pkg::CFG_KMER_LENGTH,   8'd0, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_CFG,  1'b0, kms_pkg::CFG_WINDOW_LENGTH, 8'd0, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_A_UP, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_A_LO, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_A_UP, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_A_LO, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_A_UP, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_A_LO, 1'b0, 32'd0, 1'b0, 64'd0},
    // all-ones data clamps both registers high; write to a hole is dropped
    '{ROW_CFG,  1'b0, kms_pkg::CFG_KMER_LENGTH,   8'hFF, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_CFG,  1'b0, kms_pkg::CFG_WINDOW_LENGTH, 8'hFF, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_CFG,  1'b0, CFG_NO_REG,                 8'h55, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b1, 8'h00, kms_pkg::CHAR_C_UP, 1'b1, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_T_LO, 1'b1, 32'd1, 1'b0, 64'd0},
    // exact maxima, changed in the middle of a sequence
    '{ROW_CFG,  1'b0, kms_pkg::CFG_KMER_LENGTH,   8'd32, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_CFG,  1'b0, kms_pkg::CFG_WINDOW_LENGTH, 8'd16, 1'b0, 32'd0, 1'b0, 64'd0},
    '{ROW_BEAT, 1'b0, 8'h00, kms_pkg::CHAR_G_UP, 1'b1, 32'd2, 1'b0, 64'd0}
  };

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT ports
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  kms_pkg::kms_in_t               in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  kms_pkg::kms_out_t              out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [kms_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [kms_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  kmer_minimizer_stream #(
    .MAX_WINDOW (WIN_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // typed expectation travels with the beat it belongs to
  logic              beat_typed = 1'b0;
  kms_pkg::kms_out_t beat_res   = '0;

  // bench control
  logic        quiet   = 1'b0;   // no idling at all
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  logic        failed  = 1'b0;
  int unsigned beats_sent   = 0;
  int unsigned results_done = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned rx_hold      = 0;

  kms_pkg::kms_out_t minimizer_q [$];

  // model state
  logic [5:0]  mdl_k = kms_pkg::KMER_LENGTH_RST;
  logic [4:0]  mdl_w = kms_pkg::WINDOW_LENGTH_RST;
  logic [63:0] seq_kmer   = '0;
  logic [5:0]  seq_filled = '0;
  logic [63:0] win_val [WIN_DEPTH];
  logic [31:0] win_pos [WIN_DEPTH];
  int unsigned win_cnt  = 0;
  logic [63:0] min_last = '1;
  logic [31:0] next_pos = '0;

  // 0..3 for a base in either case, -1 otherwise
  function automatic int base_code_of(input logic [7:0] c);
    int code;
    case (c)
      kms_pkg::CHAR_A_UP, kms_pkg::CHAR_A_LO: code = int'(kms_pkg::BASE_A);
      kms_pkg::CHAR_C_UP, kms_pkg::CHAR_C_LO: code = int'(kms_pkg::BASE_C);
      kms_pkg::CHAR_G_UP, kms_pkg::CHAR_G_LO: code = int'(kms_pkg::BASE_G);
      kms_pkg::CHAR_T_UP, kms_pkg::CHAR_T_LO: code = int'(kms_pkg::BASE_T);
      default:                                code = -1;
    endcase
    return code;
  endfunction

  function automatic void track_clear();
    seq_kmer   = '0;
    seq_filled = '0;
    win_cnt    = 0;
    min_last   = '1;
  endfunction

  // smaller of the k-mer and its reverse complement
  function automatic logic [63:0] canonical_of(input logic [63:0] fwd, input int unsigned k,
                                               input logic [63:0] kmask);
    logic [63:0] comp;
    logic [63:0] rc;
    comp = ~fwd & kmask;
    rc   = '0;
    for (int i = 0; i < 32; i++) begin
      rc[63-2*i -: 2] = comp[2*i +: 2];
    end
    rc = rc >> (64 - 2 * k);
    return (rc < fwd) ? rc : fwd;
  endfunction

  // one character in, one result out; updates the model state
  function automatic kms_pkg::kms_out_t minimizer_step(input kms_pkg::kms_in_t b);
    kms_pkg::kms_out_t r;
    int          code;
    int unsigned k;
    int unsigned w;
    logic [63:0] kmask;
    logic [63:0] cb;
    logic [63:0] mv;
    logic [31:0] mp;
    r = '0;
    if (b.start_of_sequence) begin
      track_clear();
      next_pos = '0;
    end
    r.base_position = next_pos;
    next_pos = next_pos + 32'd1;

    code = base_code_of(b.base_char);
    if (code < 0) begin
      track_clear();
      return r;
    end

    k = mdl_k;
    if (k < 1) k = 1;
    if (k > 32) k = 32;
    kmask = (k == 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    seq_kmer = ((seq_kmer << 2) | 64'(code)) & kmask;
    if (seq_filled < kms_pkg::FILL_MAX) seq_filled = seq_filled + 6'd1;
    if (seq_filled < k) return r;

    cb = canonical_of(seq_kmer, k, kmask);
    r.kmer_valid     = 1'b1;
    r.canonical_kmer = cb;

    // newest entry at index 0
    for (int i = WIN_DEPTH - 1; i > 0; i--) begin
      win_val[i] = win_val[i-1];
      win_pos[i] = win_pos[i-1];
    end
    win_val[0] = cb;
    win_pos[0] = r.base_position;
    if (win_cnt < WIN_DEPTH) win_cnt++;

    w = mdl_w;
    if (w < kms_pkg::WINDOW_MIN) w = kms_pkg::WINDOW_MIN;
    if (w > WIN_DEPTH) w = WIN_DEPTH;
    if (win_cnt >= w) begin
      // oldest first, strict compare keeps the earliest on ties
      mv = win_val[w-1];
      mp = win_pos[w-1];
      for (int i = w - 1; i > 0; i--) begin
        if (win_val[i-1] < mv) begin
          mv = win_val[i-1];
          mp = win_pos[i-1];
        end
      end
      if (mv != min_last) begin
        min_last             = mv;
        r.new_minimizer      = 1'b1;
        r.minimizer_position = mp;
        r.minimizer_value    = mv;
      end
    end
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [63:0] want_v,
                            input logic [63:0] got_v);
    failed = 1'b1;
    $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
  endtask

  // track register writes, predict on input beats, check output beats
  kms_pkg::kms_out_t pred;
  kms_pkg::kms_out_t want;
  kms_pkg::kms_out_t got;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kms_pkg::CFG_KMER_LENGTH:   mdl_k = cfg_data[5:0];
          kms_pkg::CFG_WINDOW_LENGTH: mdl_w = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pred = minimizer_step(in_data);
        minimizer_q.insert(minimizer_q.size(), beat_typed ? beat_res : pred);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        results_done <= results_done + 1;
        if (minimizer_q.size() == 0) begin
          failed = 1'b1;
          $error("result beat with nothing expected, base_position 0x%0h",
                 got.base_position);
        end else begin
          want = minimizer_q.pop_front();
          if (got.base_position !== want.base_position)
            flag_field("base_position", 64'(want.base_position), 64'(got.base_position));
          if (got.kmer_valid !== want.kmer_valid)
            flag_field("kmer_valid", 64'(want.kmer_valid), 64'(got.kmer_valid));
          if (got.canonical_kmer !== want.canonical_kmer)
            flag_field("canonical_kmer", want.canonical_kmer, got.canonical_kmer);
          if (got.new_minimizer !== want.new_minimizer)
            flag_field("new_minimizer", 64'(want.new_minimizer), 64'(got.new_minimizer));
          if (got.minimizer_position !== want.minimizer_position)
            flag_field("minimizer_position", 64'(want.minimizer_position),
                       64'(got.minimizer_position));
          if (got.minimizer_value !== want.minimizer_value)
            flag_field("minimizer_value", want.minimizer_value, got.minimizer_value);
        end
      end
    end
  end

  // receiver: ready drops in bursts of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold   <= 0;
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (!quiet && !rx_calm && $urandom_range(0, 7) == 0) begin
      rx_hold   <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // sender idle burst
  task automatic sender_gap();
    if (!quiet && !tx_calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // present one character beat and hold it until taken
  task automatic send_beat(input kms_pkg::kms_in_t b, input logic typed,
                           input kms_pkg::kms_out_t tres);
    in_valid   <= 1'b1;
    in_data    <= b;
    beat_typed <= typed;
    beat_res   <= tres;
    do begin
      @(posedge clk);
    end while (!in_ready);
    beats_sent++;
  endtask

  // register write, only once every result is out; cfg_valid left high
  task automatic write_reg(input logic [kms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kms_pkg::CFG_DATA_W-1:0] val);
    if (in_valid) in_valid <= 1'b0;
    while (results_done != beats_sent) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
  endtask

  // stimulus
  initial begin
    dir_row_t          row;
    kms_pkg::kms_in_t  beat;
    kms_pkg::kms_out_t tres;
    logic [7:0]  ch;
    logic [7:0]  kval;
    logic [7:0]  wval;
    int unsigned rand_items;
    int unsigned phase_len;
    int unsigned bad_div;
    int unsigned skip;

    rand_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TAB[r];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.val);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        sender_gap();
        beat.start_of_sequence = row.sos;
        beat.base_char         = row.val;
        tres                   = '0;
        tres.base_position     = row.t_pos;
        tres.kmer_valid        = row.t_kvalid;
        tres.canonical_kmer    = row.t_kmer;
        send_beat(beat, row.typed, tres);
      end
    end

    // random phases, each with its own settings
    while (rand_items < RAND_ITEMS) begin
      quiet   = (rand_items + TAIL_ITEMS >= RAND_ITEMS);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);

      case ($urandom_range(0, 9))
        0:       kval = 8'd1;
        1:       kval = 8'd32;
        2:       kval = 8'd0;
        3:       kval = 8'($urandom_range(33, 63));
        4:       kval = 8'hC0 | 8'($urandom_range(1, 32));  // upper bits dropped
        default: kval = 8'($urandom_range(1, 32));
      endcase
      case ($urandom_range(0, 9))
        0:       wval = 8'd5;
        1:       wval = 8'd16;
        2:       wval = 8'($urandom_range(0, 4));
        3:       wval = 8'($urandom_range(17, 31));
        4:       wval = 8'hE0 | 8'($urandom_range(5, 16));
        default: wval = 8'($urandom_range(5, 16));
      endcase
      // mostly both registers, sometimes only one
      skip = $urandom_range(0, 5);
      if (skip != 0) write_reg(kms_pkg::CFG_KMER_LENGTH, kval);
      if (skip != 1) write_reg(kms_pkg::CFG_WINDOW_LENGTH, wval);
      cfg_valid <= 1'b0;

      // odds of a non-base character: rare enough for long runs, or frequent
      case ($urandom_range(0, 2))
        0:       bad_div = 300;
        1:       bad_div = 30;
        default: bad_div = 8;
      endcase
      phase_len = $urandom_range(60, 200);

      for (int n = 0; n < phase_len; n++) begin
        if (n == 0) beat.start_of_sequence = ($urandom_range(0, 1) == 1);
        else        beat.start_of_sequence = ($urandom_range(0, 249) == 0);
        if ($urandom_range(1, bad_div) == 1) begin
          do begin
            ch = 8'($urandom_range(0, 255));
          end while (base_code_of(ch) >= 0);
        end else begin
          case ($urandom_range(0, 7))
            0:       ch = kms_pkg::CHAR_A_UP;
            1:       ch = kms_pkg::CHAR_C_UP;
            2:       ch = kms_pkg::CHAR_G_UP;
            3:       ch = kms_pkg::CHAR_T_UP;
            4:       ch = kms_pkg::CHAR_A_LO;
            5:       ch = kms_pkg::CHAR_C_LO;
            6:       ch = kms_pkg::CHAR_G_LO;
            default: ch = kms_pkg::CHAR_T_LO;
          endcase
        end
        beat.base_char = ch;
        sender_gap();
        send_beat(beat, 1'b0, '0);
        rand_items++;
      end
    end

    // drain, then give the pipe time to show any stray beat
    if (in_valid) in_valid <= 1'b0;
    while (results_done != beats_sent) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (failed || minimizer_q.size() != 0) begin
      $display("Simulation FAILED");
    end else begin
      $display("Simulation PASSED");
    end
    $finish;
  end

endmodule
